>>> hdl/mavg_pkg.sv
`timescale 1ns / 1ps
// shared constants for the three-axis moving average block
// no dependencies

package mavg_pkg;

   // default ring depth and sample width
   localparam int WINDOW_MAX_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 32;

   // width of the window register and of the sample count
   localparam int CNT_W   = 7;
   localparam int CNT_MAX = (2 ** CNT_W) - 1;

   // window size after reset
   localparam int DEFAULT_WINDOW = 10;

   // number of axes held per ring entry
   localparam int AXES = 3;

endpackage

>>> hdl/mavg_ring.sv
`timescale 1ns / 1ps
// sample ring: one write port, one read port, registered read data
// depends on nothing but its parameters

module mavg_ring #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/mavg_div.sv
`timescale 1ns / 1ps
// bit-serial signed by unsigned divider, truncates toward zero
// depends on mavg_pkg

module mavg_div #(
   parameter int SUM_BITS = 38,
   parameter int Q_BITS   = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [SUM_BITS-1:0]  dividend,
   input  logic [mavg_pkg::CNT_W-1:0]  divisor,
   output logic                        done,
   output logic signed [Q_BITS-1:0]    quotient
);
   import mavg_pkg::*;

   localparam int STEP_W = $clog2(SUM_BITS + 1);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   div_state_type         state_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [SUM_BITS-1:0]   dq_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [CNT_W-1:0]      dsr_ff;
   logic                  neg_ff;

   logic [SUM_BITS-1:0]   mag;
   logic [CNT_W:0]        trial;
   logic [CNT_W:0]        diff;
   logic                  take;
   logic [CNT_W-1:0]      rem_in;
   logic [Q_BITS-1:0]     q_mag;

   // magnitude of the dividend, most negative value maps to its unsigned magnitude
   assign mag = dividend[SUM_BITS-1] ? (~dividend + SUM_BITS'(1)) : dividend;

   // one restoring step
   assign trial  = {rem_ff, dq_ff[SUM_BITS-1]};
   assign diff   = trial - {1'b0, dsr_ff};
   assign take   = ~diff[CNT_W];
   assign rem_in = take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else if (start) begin
         state_ff <= DIV_RUN;
         step_ff  <= STEP_W'(SUM_BITS);
         dq_ff    <= mag;
         rem_ff   <= '0;
         dsr_ff   <= divisor;
         neg_ff   <= dividend[SUM_BITS-1];
      end else begin
         unique case (state_ff)
            DIV_IDLE: begin
               state_ff <= DIV_IDLE;
            end
            DIV_RUN: begin
               dq_ff   <= {dq_ff[SUM_BITS-2:0], take};
               rem_ff  <= rem_in;
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == STEP_W'(1)) begin
                  state_ff <= DIV_DONE;
               end
            end
            DIV_DONE: begin
               state_ff <= DIV_DONE;
            end
            default: begin
               state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   assign done     = (state_ff == DIV_DONE);
   assign q_mag    = dq_ff[Q_BITS-1:0];
   assign quotient = neg_ff ? (~q_mag + Q_BITS'(1)) : q_mag;

endmodule

>>> hdl/moving_average_3axis.sv
`timescale 1ns / 1ps
// three-axis moving average top level: sequencer, running sums, output register
// depends on mavg_pkg, mavg_ring, mavg_div

// Each req transaction carries one (x, y, z) sample in signed fixed point. The
// sample is written into a ring memory of WINDOW_MAX entries and added to three
// running sums; once the ring holds the configured window of samples the oldest
// one is read back and subtracted first. Each rsp transaction returns the three
// sums divided by the number of samples held (truncated toward zero) plus that
// count, one rsp per req, in order. A new req is not taken until the previous
// average has been loaded into the output register; the three bit-serial
// dividers produce one quotient bit per cycle. The output register lets a new
// sample be taken while the previous rsp is still stalled; a finished average
// waits until that register is free. The ring contents are undefined after
// reset and get no clearing pass; only written entries are ever subtracted
// from the sums. Writing csr_win_len (0 acts as 1, values above WINDOW_MAX
// saturate) restarts the average from empty, and is meant for idle periods.

module moving_average_3axis #(
   parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // sample input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_BITS-1:0]    req_pos_x,
   input  logic signed [SAMPLE_BITS-1:0]    req_pos_y,
   input  logic signed [SAMPLE_BITS-1:0]    req_pos_z,
   // average output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]    rsp_avg_x,
   output logic signed [SAMPLE_BITS-1:0]    rsp_avg_y,
   output logic signed [SAMPLE_BITS-1:0]    rsp_avg_z,
   output logic [mavg_pkg::CNT_W-1:0]       rsp_sample_count,
   // window length register
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mavg_pkg::CNT_W-1:0]       csr_win_len
);
   import mavg_pkg::*;

   localparam int PTR_W   = $clog2(WINDOW_MAX);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX);
   localparam int IDX_W   = PTR_W + 2;
   localparam int ENTRY_W = AXES * SAMPLE_BITS;
   localparam int EXT_W   = SUM_W - SAMPLE_BITS;

   // largest usable window: bounded by the ring and by the register width
   localparam logic [CNT_W-1:0] WIN_CAP =
      CNT_W'((WINDOW_MAX > CNT_MAX) ? CNT_MAX : WINDOW_MAX);
   localparam logic [CNT_W-1:0] WIN_RESET =
      CNT_W'((DEFAULT_WINDOW > WINDOW_MAX) ? WINDOW_MAX : DEFAULT_WINDOW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LAUNCH,
      ST_WAIT
   } seq_state_type;

   // sequencer and window state
   seq_state_type             state_ff;
   logic [CNT_W-1:0]          win_ff;
   logic [CNT_W-1:0]          held_ff;
   logic [CNT_W-1:0]          held_in;
   logic [PTR_W-1:0]          wp_ff;
   logic [PTR_W-1:0]          wp_in;
   logic                      evict_ff;

   // running sums
   logic signed [SUM_W-1:0]   sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [SUM_W-1:0]   sum_x_in, sum_y_in, sum_z_in;

   // sample latched at acceptance
   logic [ENTRY_W-1:0]        smp_ff;

   // output register
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_avg_x_ff, rsp_avg_y_ff, rsp_avg_z_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   // handshakes
   logic                      req_take;
   logic                      csr_take;
   logic                      rsp_free;
   logic                      rsp_load;

   // oldest-entry address
   logic [IDX_W-1:0]          old_raw;
   logic [IDX_W-1:0]          old_ix;
   logic [PTR_W-1:0]          old_addr;
   logic                      evict_in;

   // ring read data split per axis
   logic [ENTRY_W-1:0]        rd_data;
   logic signed [SUM_W-1:0]   old_x, old_y, old_z;
   logic signed [SUM_W-1:0]   new_x, new_y, new_z;

   // dividers
   logic                      div_start;
   logic                      done_x, done_y, done_z;
   logic                      div_all_done;
   logic signed [SAMPLE_BITS-1:0] q_x, q_y, q_z;

   logic [CNT_W-1:0]          win_wr;

   assign req_stall = (state_ff != ST_IDLE) | csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign csr_take  = csr_valid & csr_ready;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // zero acts as one, anything beyond the ring saturates
   assign win_wr = (csr_win_len == '0)     ? CNT_W'(1) :
                   (csr_win_len > WIN_CAP) ? WIN_CAP   : csr_win_len;

   // full window: drop the entry written held_ff transactions ago
   assign evict_in = (held_ff >= win_ff);
   assign old_raw  = IDX_W'(wp_ff) + IDX_W'(WINDOW_MAX) - IDX_W'(held_ff);
   assign old_ix   = (old_raw >= IDX_W'(WINDOW_MAX)) ? (old_raw - IDX_W'(WINDOW_MAX)) : old_raw;
   assign old_addr = PTR_W'(old_ix);

   mavg_ring #(
      .DEPTH (WINDOW_MAX),
      .WIDTH (ENTRY_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPDATE),
      .wr_addr (wp_ff),
      .wr_data (smp_ff),
      .rd_en   (req_take),
      .rd_addr (old_addr),
      .rd_data (rd_data)
   );

   // sign-extend ring and new samples to the sum width
   assign old_x = {{EXT_W{rd_data[3*SAMPLE_BITS-1]}}, rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS]};
   assign old_y = {{EXT_W{rd_data[2*SAMPLE_BITS-1]}}, rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]};
   assign old_z = {{EXT_W{rd_data[SAMPLE_BITS-1]}},   rd_data[SAMPLE_BITS-1:0]};
   assign new_x = {{EXT_W{smp_ff[3*SAMPLE_BITS-1]}},  smp_ff[3*SAMPLE_BITS-1:2*SAMPLE_BITS]};
   assign new_y = {{EXT_W{smp_ff[2*SAMPLE_BITS-1]}},  smp_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]};
   assign new_z = {{EXT_W{smp_ff[SAMPLE_BITS-1]}},    smp_ff[SAMPLE_BITS-1:0]};

   // read-modify-write of the sums: oldest sample out, newest in
   assign sum_x_in = sum_x_ff + new_x - (evict_ff ? old_x : '0);
   assign sum_y_in = sum_y_ff + new_y - (evict_ff ? old_y : '0);
   assign sum_z_in = sum_z_ff + new_z - (evict_ff ? old_z : '0);

   // an eviction keeps the count, otherwise it grows by one
   assign held_in = evict_ff ? held_ff : (held_ff + CNT_W'(1));
   assign wp_in   = (wp_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : (wp_ff + PTR_W'(1));

   assign div_start    = (state_ff == ST_LAUNCH);
   assign div_all_done = done_x & done_y & done_z;

   // finished average moves into a free output register
   assign rsp_load = (state_ff == ST_WAIT) & div_all_done & rsp_free;

   mavg_div #(.SUM_BITS (SUM_W), .Q_BITS (SAMPLE_BITS)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_x_ff),
      .divisor  (held_ff),
      .done     (done_x),
      .quotient (q_x)
   );

   mavg_div #(.SUM_BITS (SUM_W), .Q_BITS (SAMPLE_BITS)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_y_ff),
      .divisor  (held_ff),
      .done     (done_y),
      .quotient (q_y)
   );

   mavg_div #(.SUM_BITS (SUM_W), .Q_BITS (SAMPLE_BITS)) u_div_z (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_z_ff),
      .divisor  (held_ff),
      .done     (done_z),
      .quotient (q_z)
   );

   // sequencer, window state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= WIN_RESET;
         held_ff      <= '0;
         wp_ff        <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         evict_ff     <= 1'b0;
      end else begin
         // output register loads a new average or drains on its own
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (csr_take) begin
                  // new window restarts averaging from empty
                  win_ff   <= win_wr;
                  held_ff  <= '0;
                  wp_ff    <= '0;
                  sum_x_ff <= '0;
                  sum_y_ff <= '0;
                  sum_z_ff <= '0;
               end else if (req_take) begin
                  smp_ff   <= {req_pos_x, req_pos_y, req_pos_z};
                  evict_ff <= evict_in;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               // oldest sample is on rd_data now, ring write happens this cycle
               sum_x_ff <= sum_x_in;
               sum_y_ff <= sum_y_in;
               sum_z_ff <= sum_z_in;
               held_ff  <= held_in;
               wp_ff    <= wp_in;
               state_ff <= ST_LAUNCH;
            end
            ST_LAUNCH: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (rsp_load) begin
                  rsp_avg_x_ff <= q_x;
                  rsp_avg_y_ff <= q_y;
                  rsp_avg_z_ff <= q_z;
                  rsp_count_ff <= held_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_avg_x        = rsp_avg_x_ff;
   assign rsp_avg_y        = rsp_avg_y_ff;
   assign rsp_avg_z        = rsp_avg_z_ff;
   assign rsp_sample_count = rsp_count_ff;

   // count never runs past the window
   a_held_in_window: assert property (@(posedge clock) disable iff (reset)
      held_ff <= win_ff)
      else $error("sample count exceeds window");

   // a full window at acceptance must evict the oldest sample
   a_evict_on_full: assert property (@(posedge clock) disable iff (reset)
      (req_take && (held_ff == win_ff)) |=> evict_ff)
      else $error("full window accepted without eviction");

   // a window write empties the ring
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_take |=> ((held_ff == '0) && (wp_ff == '0)))
      else $error("window write did not clear the ring");

   // a finished average is loaded whenever the output register is free
   a_rsp_from_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && rsp_free && div_all_done) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished average was not loaded");

endmodule

>>> verif/tb_moving_average_3axis.sv
`timescale 1ns / 1ps
// self-checking testbench for moving_average_3axis: directed and random samples,
// window size changes between phases, a scoreboard that predicts every average
// depends on mavg_pkg and the moving_average_3axis rtl

module tb_moving_average_3axis;
   import mavg_pkg::*;

   localparam int SW   = SAMPLE_BITS_DEFAULT;
   localparam int RING = WINDOW_MAX_DEFAULT;

   // cycles with no transaction on any channel before the run is declared hung
   localparam int HANG_LIMIT = 1500;

   localparam logic signed [SW-1:0] POS_FULL = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] NEG_FULL = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] MINUS_ONE = {SW{1'b1}};
   localparam logic signed [SW-1:0] ZERO = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [SW-1:0] req_pos_x = '0;
   logic signed [SW-1:0] req_pos_y = '0;
   logic signed [SW-1:0] req_pos_z = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [SW-1:0] rsp_avg_x;
   logic signed [SW-1:0] rsp_avg_y;
   logic signed [SW-1:0] rsp_avg_z;
   logic [CNT_W-1:0]     rsp_sample_count;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CNT_W-1:0]     csr_win_len = '0;

   // when set, neither side idles: sender gaps and receiver stalls are off
   logic calm = 1'b0;

   int quiet_cycles = 0;

   typedef struct {
      logic signed [SW-1:0] avg_x;
      logic signed [SW-1:0] avg_y;
      logic signed [SW-1:0] avg_z;
      logic [CNT_W-1:0]     count;
   } average_type;

   // running-sum predictor plus the queue of averages still owed by the block
   class mavg_scoreboard_type;
      logic signed [SW-1:0] ring_x [RING];
      logic signed [SW-1:0] ring_y [RING];
      logic signed [SW-1:0] ring_z [RING];
      longint               sum_x, sum_y, sum_z;
      int unsigned          wr_ptr, held;
      logic [CNT_W-1:0]     window;
      average_type          pending [$];
      int                   mismatches;

      function new();
         mismatches = 0;
         set_window(CNT_W'(DEFAULT_WINDOW));
      endfunction

      // any window write restarts the average from empty
      function void set_window(input logic [CNT_W-1:0] w);
         window = w;
         sum_x  = 0;
         sum_y  = 0;
         sum_z  = 0;
         wr_ptr = 0;
         held   = 0;
      endfunction

      // accepted sample: update ring and sums, queue the average it yields
      function void note_sample(input logic signed [SW-1:0] x, y, z);
         int unsigned span;
         int unsigned oldest;
         longint      q;
         average_type want;
         // zero acts as one, anything past the ring depth saturates
         span = (window == 0) ? 1 : ((window > RING) ? RING : window);
         if (held >= span) begin
            oldest = (wr_ptr + RING - held) % RING;
            sum_x -= ring_x[oldest];
            sum_y -= ring_y[oldest];
            sum_z -= ring_z[oldest];
            held--;
         end
         ring_x[wr_ptr] = x;
         ring_y[wr_ptr] = y;
         ring_z[wr_ptr] = z;
         sum_x += x;
         sum_y += y;
         sum_z += z;
         held++;
         wr_ptr = (wr_ptr + 1) % RING;
         // signed longint division truncates toward zero
         q = sum_x / longint'(held);
         want.avg_x = q[SW-1:0];
         q = sum_y / longint'(held);
         want.avg_y = q[SW-1:0];
         q = sum_z / longint'(held);
         want.avg_z = q[SW-1:0];
         want.count = CNT_W'(held);
         pending.insert(pending.size(), want);
      endfunction

      function void check_average(input average_type got);
         average_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected average x=%0d y=%0d z=%0d count=%0d",
                        $realtime, got.avg_x, got.avg_y, got.avg_z, got.count);
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got.avg_x !== want.avg_x || got.avg_y !== want.avg_y ||
             got.avg_z !== want.avg_z || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: average mismatch exp x=%0d y=%0d z=%0d count=%0d,",
                         " got x=%0d y=%0d z=%0d count=%0d"},
                        $realtime, want.avg_x, want.avg_y, want.avg_z, want.count,
                        got.avg_x, got.avg_y, got.avg_z, got.count);
         end
      endfunction
   endclass

   mavg_scoreboard_type sb = new();

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   moving_average_3axis u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_avg_x        (rsp_avg_x),
      .rsp_avg_y        (rsp_avg_y),
      .rsp_avg_z        (rsp_avg_z),
      .rsp_sample_count (rsp_sample_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_win_len      (csr_win_len)
   );

   // result side: check every accepted transaction, stall at random, watch for a hang
   always @(posedge clock) begin
      average_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.avg_x = rsp_avg_x;
            got.avg_y = rsp_avg_y;
            got.avg_z = rsp_avg_z;
            got.count = rsp_sample_count;
            sb.check_average(got);
         end
         // any handshake on any channel counts as progress
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("moving_average_3axis verification failed");
            $finish;
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 26);
   end

   function automatic logic signed [SW-1:0] pick_extreme();
      case ($urandom_range(3))
         0: return POS_FULL;
         1: return NEG_FULL;
         2: return MINUS_ONE;
         default: return ZERO;
      endcase
   endfunction

   // mostly full-range values, with extremes and small values near zero mixed in
   function automatic logic signed [SW-1:0] pick_coord();
      int near;
      case ($urandom_range(9))
         0, 1: return pick_extreme();
         2, 3: begin
            near = int'($urandom_range(2000)) - 1000;
            return SW'(near);
         end
         default: return SW'($urandom);
      endcase
   endfunction

   // one sample transaction; idle cycles first at random, payload held while stalled
   task automatic send_sample(input logic signed [SW-1:0] x, y, z);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (req_stall);
      sb.note_sample(x, y, z);
   endtask

   // block until every owed average has come back, then realign to a rising edge
   task automatic wait_drained();
      while (sb.pending.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_window(input logic [CNT_W-1:0] w);
      csr_valid   <= 1'b1;
      csr_win_len <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_window(w);
   endtask

   // one setting of the window, then random samples with runs of constant extremes
   task automatic run_phase(input logic [CNT_W-1:0] w, input int items, input logic quiet);
      int                   sent;
      int                   run_len;
      logic signed [SW-1:0] hx, hy, hz;
      req_valid <= 1'b0;
      wait_drained();
      write_window(w);
      calm <= quiet;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(7) == 0) begin
            // long runs of the same extreme push the sums toward their limits
            run_len = $urandom_range(5, 70);
            hx = pick_extreme();
            hy = pick_extreme();
            hz = pick_extreme();
            while (run_len > 0 && sent < items) begin
               send_sample(hx, hy, hz);
               run_len--;
               sent++;
            end
         end else begin
            send_sample(pick_coord(), pick_coord(), pick_coord());
            sent++;
         end
      end
      calm <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, at the window left by reset: fill it with extremes and wrap once
      for (int i = 0; i < 11; i++)
         send_sample(POS_FULL, NEG_FULL, (i % 2 == 1) ? MINUS_ONE : ZERO);
      send_sample(NEG_FULL, POS_FULL, SW'(1));
      send_sample(NEG_FULL, NEG_FULL, NEG_FULL);
      send_sample(POS_FULL, POS_FULL, POS_FULL);
      // small negative sums must round toward zero
      send_sample(SW'(-3), SW'(-7), SW'(5));
      send_sample(SW'(1), SW'(2), SW'(-9));

      // random phases: window of zero, one, full depth, saturating values, odd sizes
      run_phase(CNT_W'(0), 30, 1'b0);
      run_phase(CNT_W'(1), 25, 1'b0);
      run_phase(CNT_W'(RING), 120, 1'b1);
      run_phase(CNT_W'(127), 80, 1'b0);
      run_phase(CNT_W'(RING + 1), 70, 1'b0);
      run_phase(CNT_W'(2), 30, 1'b0);
      run_phase(CNT_W'($urandom_range(1, RING)), 60, 1'b0);
      run_phase(CNT_W'(3), 20, 1'b0);
      run_phase(CNT_W'($urandom_range(0, CNT_MAX)), 60, 1'b0);
      run_phase(CNT_W'(RING - 1), 55, 1'b0);

      req_valid <= 1'b0;
      wait_drained();
      // room for any stray late transaction to show up
      repeat (60) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("moving_average_3axis verification clean");
      else
         $display("moving_average_3axis verification failed");
      $finish;
   end

endmodule

>>> files.f
hdl/mavg_pkg.sv
hdl/mavg_ring.sv
hdl/mavg_div.sv
hdl/moving_average_3axis.sv
verif/tb_moving_average_3axis.sv
